[sv/b2d_pkg.sv]
`default_nettype none
package b2d_pkg;

  localparam int unsigned N_BITS   = 64;
  localparam int unsigned N_DIGITS = 20;
  localparam int unsigned CNT_W    = 6;

  localparam logic [CNT_W-1:0] CNT_CONV_LAST  = CNT_W'(N_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_DIGIT_LAST = CNT_W'(N_DIGITS - 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } b2d_state_t;

  // per-cycle command broadcast to every digit cell
  typedef struct packed {
    logic clr;
    logic dabble;
    logic dshift;
  } b2d_ctl_t;

endpackage
`default_nettype wire

[sv/b2d_cell.sv]
`default_nettype none
module b2d_cell
  import b2d_pkg::*;
(
  input  logic       clk,
  input  b2d_ctl_t   ctl,
  input  logic       bit_in,
  input  logic [3:0] digit_in,
  output logic       bit_out,
  output logic [3:0] digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] corr;

  // add-3 correction before the shift; carry out depends only on this cell's register
  assign corr    = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out = corr[3];
  assign digit   = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clr) begin
      digit_nxt = 4'd0;
    end else if (ctl.dabble) begin
      digit_nxt = {corr[2:0], bit_in};
    end else if (ctl.dshift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule
`default_nettype wire

[sv/binary_to_decimal_ascii.sv]
// Channel | Handshake              | Payload
// input   | in_valid / in_ready    | in_value, in_signed_mode
// result  | out_valid / out_ready  | out_char_out, out_last_char
//
// One number at a time: it is taken, then shift-and-add-3 runs over its 64 bits through a row
// of 20 BCD digit cells; leading zeros are dropped to find the top digit, a minus sign is sent
// for a negative number, and the digits go out top first, each held while the output stalls.
// rst_n is synchronous, active low; it clears the control state and the output valid flag.
// A stalled result holds the sequencer; the next number is taken once its final character
// sits in the output register.
`default_nettype none
module binary_to_decimal_ascii
  import b2d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [N_BITS-1:0] in_value,
  input  logic              in_signed_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char_out,
  output logic              out_last_char
);

  b2d_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [N_BITS-1:0] bin_r, bin_nxt;
  logic              neg_r, neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  b2d_ctl_t ctl;
  logic     in_xfer;
  logic     slot_free;
  logic     load_sign;
  logic     load_digit;
  logic     in_neg;
  logic     bit_c [N_DIGITS];
  logic [3:0] dig [N_DIGITS];
  logic [3:0] top_digit;
  logic       top_zero;
  logic       cnt_at_last_digit;

  assign in_xfer           = in_valid && in_ready;
  assign slot_free         = !out_valid_r || out_ready;
  assign top_digit         = dig[N_DIGITS-1];
  assign top_zero          = (top_digit == 4'd0);
  assign cnt_at_last_digit = (cnt_r == CNT_DIGIT_LAST);
  assign in_neg            = in_signed_mode && in_value[N_BITS-1];

  genvar g;
  generate
    for (g = 0; g < N_DIGITS; g++) begin : g_cell
      if (g == 0) begin : g_first
        b2d_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .bit_in   (bin_r[N_BITS-1]),
          .digit_in (4'd0),
          .bit_out  (bit_c[g]),
          .digit    (dig[g])
        );
      end else begin : g_rest
        b2d_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .bit_in   (bit_c[g-1]),
          .digit_in (dig[g-1]),
          .bit_out  (bit_c[g]),
          .digit    (dig[g])
        );
      end
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CONV;
      ST_CONV: if (cnt_r == CNT_CONV_LAST) state_nxt = ST_SKIP;
      ST_SKIP: begin
        if (!top_zero || cnt_at_last_digit) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: if (slot_free) state_nxt = ST_EMIT;
      ST_EMIT: if (slot_free && cnt_at_last_digit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    ctl        = '0;
    load_sign  = 1'b0;
    load_digit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.clr  = in_valid;
      end
      ST_CONV: ctl.dabble = 1'b1;
      ST_SKIP: ctl.dshift = top_zero && !cnt_at_last_digit;
      ST_SIGN: load_sign = slot_free;
      ST_EMIT: begin
        load_digit = slot_free;
        ctl.dshift = slot_free;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // datapath registers
  always_comb begin
    bin_nxt       = bin_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_xfer) begin
      neg_nxt = in_neg;
      bin_nxt = in_neg ? (~in_value + N_BITS'(1)) : in_value;
      cnt_nxt = '0;
    end else if (ctl.dabble) begin
      bin_nxt = {bin_r[N_BITS-2:0], 1'b0};
      cnt_nxt = (cnt_r == CNT_CONV_LAST) ? '0 : cnt_r + CNT_W'(1);
    end else if (ctl.dshift) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (load_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_MINUS;
      out_last_nxt  = 1'b0;
    end else if (load_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_ZERO | {4'd0, top_digit};
      out_last_nxt  = cnt_at_last_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

endmodule
`default_nettype wire

[sv/b2d_checker.sv]
`default_nettype none
module b2d_checker
  import b2d_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_out,
  input logic       out_last_char
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_char_out) && $stable(out_last_char))
    else $error("result changed while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_out == CHAR_MINUS) ||
                  ((out_char_out >= CHAR_ZERO) && (out_char_out <= (CHAR_ZERO + 8'd9))))
    else $error("character outside '-' and '0'..'9'");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_out == CHAR_MINUS) |-> !out_last_char)
    else $error("sign marked as final character");

  a_ready_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last_char)
    else $error("new number taken before previous text finished");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second number taken during conversion");

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_out  (out_char_out),
  .out_last_char (out_last_char)
);
`default_nettype wire

[verif/binary_to_decimal_ascii_test.sv]
`timescale 1ns / 1ps
module binary_to_decimal_ascii_test;
  import b2d_pkg::*;

  typedef struct packed {
    logic [N_BITS-1:0] value;
    logic              signed_mode;
  } number_t;

  // Expected decimal text, one character per transfer, oldest first.
  class text_scoreboard;
    logic [7:0] char_q[$];
    logic       last_q[$];
    int unsigned errors;

    function void note_number(logic [N_BITS-1:0] value, logic signed_mode);
      logic [N_BITS-1:0] mag;
      logic [7:0] digit_q[$];
      logic neg;
      neg = signed_mode && value[N_BITS-1];
      // two's complement magnitude; the most negative value wraps to 2^63
      mag = neg ? (~value + 1'b1) : value;
      if (mag == '0) begin
        char_q.push_back(CHAR_ZERO);
        last_q.push_back(1'b1);
        return;
      end
      while (mag != '0) begin
        digit_q.push_front(CHAR_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end
      if (neg) begin
        char_q.push_back(CHAR_MINUS);
        last_q.push_back(1'b0);
      end
      foreach (digit_q[i]) begin
        char_q.push_back(digit_q[i]);
        last_q.push_back(i == digit_q.size() - 1);
      end
    endfunction

    function void check_char(logic [7:0] char_out, logic last_char);
      logic [7:0] exp_char;
      logic       exp_last;
      if (char_q.size() == 0) begin
        $error("out_char_out: no character expected, got %h", char_out);
        errors++;
        return;
      end
      exp_char = char_q.pop_front();
      exp_last = last_q.pop_front();
      if (char_out !== exp_char) begin
        $error("out_char_out: expected %h, got %h", exp_char, char_out);
        errors++;
      end
      if (last_char !== exp_last) begin
        $error("out_last_char: expected %b, got %b", exp_last, last_char);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return char_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [N_BITS-1:0] in_value;
  logic              in_signed_mode;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_char_out;
  logic              out_last_char;

  text_scoreboard sb;
  bit no_idle;

  number_t corner_numbers [20] = '{
    '{64'd0, 1'b0},
    '{64'd0, 1'b1},
    '{64'd1, 1'b0},
    '{64'd9, 1'b1},
    '{64'd10, 1'b0},
    '{64'd99, 1'b1},
    '{64'd100, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{64'h8000_0000_0000_0000, 1'b1},
    '{64'h8000_0000_0000_0000, 1'b0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0},
    '{64'd9999999999999999999, 1'b0},
    '{64'd10000000000000000000, 1'b0},
    '{64'd10000000000000000000, 1'b1},
    '{64'hFFFF_FFFF_FFFF_FFF6, 1'b1},
    '{64'hFFFF_FFFF_FFFF_FFF6, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFF7, 1'b1},
    '{64'hAAAA_AAAA_5555_5555, 1'b1}
  };

  binary_to_decimal_ascii dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_signed_mode (in_signed_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_last_char  (out_last_char)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Valid stays up across back-to-back numbers; it only drops for a gap or a drain.
  task automatic send_number(input logic [N_BITS-1:0] value, input logic mode);
    int unsigned gap;
    bit ready_seen;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_signed_mode <= mode;
    // inputs only move at the rising edge, so the falling edge shows the
    // values the next rising edge will see
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
    sb.note_number(value, mode);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic take_chars();
    int unsigned gap;
    bit valid_seen;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        valid_seen = out_valid;
        @(posedge clk);
      end while (!valid_seen);
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_char(out_char_out, out_last_char);
  end

  initial begin
    logic [N_BITS-1:0] raw;
    logic [N_BITS-1:0] value;
    int unsigned width;
    sb             = new();
    no_idle        = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value       = '0;
    in_signed_mode = 1'b0;
    out_ready      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      take_chars();
    join_none

    foreach (corner_numbers[i])
      send_number(corner_numbers[i].value, corner_numbers[i].signed_mode);
    drain_block();

    for (int i = 0; i < 280; i++) begin
      if (i % 40 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      if (i == 140)
        drain_block();
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0, 1: value = raw;
        2: begin
          width = $urandom_range(1, 63);
          value = raw & ((64'd1 << width) - 1);
        end
        3: begin
          // small negative numbers
          width = $urandom_range(1, 24);
          value = ~(raw & ((64'd1 << width) - 1)) + 1'b1;
        end
        default: value = 64'($urandom_range(0, 1000));
      endcase
      send_number(value, 1'($urandom));
    end

    drain_block();
    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
